[design/set_assoc_cache_tag_model_top_macros.svh]
// Assertion macros for the cache tag model checker
`ifndef SET_ASSOC_CACHE_TAG_MODEL_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_MODEL_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SACT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[design/sact_pkg.sv]
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants for the cache tag model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sact_pkg;
    localparam int DEF_MAX_SETS = 1024;
    localparam int DEF_MAX_WAYS = 8;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;
    localparam logic [1:0] REG_POLICY = 2'd3;

    localparam logic POL_LRU   = 1'b0;
    localparam logic POL_FIXED = 1'b1;

    typedef struct packed {
        logic        is_write;
        logic [31:0] address;
    } sact_in_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_accesses;
        logic [31:0] read_misses;
        logic [31:0] write_accesses;
        logic [31:0] write_misses;
    } sact_out_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } sact_state_t;
endpackage

[design/sact_front.sv]
// ----------------------------------------------------------------------------
// sact_front
// Splits each address into set and tag and queues the word for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sact_front import sact_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  sact_in_t        in_word,
    input  logic [3:0]      offset_bits,
    input  logic [3:0]      index_bits,
    output logic            q_valid,
    input  logic            q_take,
    output logic            q_write,
    output logic [SW-1:0]   q_set,
    output logic [31:0]     q_tag
);
    logic [31:0] above, imask, idx, tag;
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_reg, rd_next, wr_reg, wr_next;
    logic        e_write [2];
    logic [SW-1:0] e_set [2];
    logic [31:0] e_tag [2];
    logic        do_push, do_pop;

    // address split (each shift count at most 15)
    always_comb
    begin
        above = in_word.address >> offset_bits;
        imask = ~(32'hFFFF_FFFF << index_bits);
        idx   = above & imask;
        tag   = above >> index_bits;
    end

    // two-entry queue
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_write = e_write[rd_reg];
    assign q_set   = e_set[rd_reg];
    assign q_tag   = e_tag[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
        rd_next  = rd_reg ^ do_pop;
        wr_next  = wr_reg ^ do_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            e_write[wr_reg] <= in_word.is_write;
            e_set[wr_reg]   <= idx[SW-1:0];
            e_tag[wr_reg]   <= tag;
        end
    end
endmodule

[design/sact_back.sv]
// ----------------------------------------------------------------------------
// sact_back
// Reads one set, updates tags, fill count and counters, emits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sact_back import sact_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WW = $clog2(MAX_WAYS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_take,
    input  logic            q_write,
    input  logic [SW-1:0]   q_set,
    input  logic [31:0]     q_tag,
    input  logic [3:0]      ways_in_use,
    input  logic            policy_mode,
    output logic            empty,
    input  logic            pop,
    output sact_out_t       out_word
);
    // one row per set: all ways of tags
    logic [MAX_WAYS-1:0][31:0] tag_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][31:0] row_rd, row_new;
    logic [WW-1:0] fill_mem [MAX_SETS];
    logic [WW-1:0] fill_rd, fill_new;
    logic [SW-1:0] clr_reg;

    sact_state_t state_reg, state_next;
    logic [SW-1:0] set_reg;
    logic [31:0]   tag_reg;
    logic          wr_reg;
    logic [31:0]   rt_reg, rm_reg, wt_reg, wm_reg;
    logic          hit_reg;
    logic          ovalid_reg;

    logic [WW-1:0] ways, fill, pos;
    logic          hit;

    // ways clamp
    always_comb
    begin
        if (ways_in_use == 4'd0)
            ways = WW'(1);
        else if (32'(ways_in_use) > MAX_WAYS)
            ways = WW'(MAX_WAYS);
        else
            ways = WW'(ways_in_use);
    end

    // search and update of one row
    always_comb
    begin
        fill = fill_rd;
        hit  = 1'b0;
        pos  = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (WW'(i) < fill && row_rd[i] == tag_reg)
            begin
                hit = 1'b1;
                pos = WW'(i);
            end
        end
        row_new  = row_rd;
        fill_new = fill;
        if (policy_mode == POL_LRU)
        begin
            if (hit || fill >= ways)
            begin
                for (int i = 0; i < MAX_WAYS - 1; i++)
                    if (WW'(i) >= (hit ? pos : WW'(0)) && WW'(i + 1) < fill)
                        row_new[i] = row_rd[i + 1];
                for (int i = 0; i < MAX_WAYS; i++)
                    if (WW'(i + 1) == fill)
                        row_new[i] = tag_reg;
            end
            else
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                    if (WW'(i) == fill)
                        row_new[i] = tag_reg;
                fill_new = fill + WW'(1);
            end
        end
        else if (!hit)
        begin
            if (fill < ways)
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                    if (WW'(i) == fill)
                        row_new[i] = tag_reg;
                fill_new = fill + WW'(1);
            end
            else
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                    if (WW'(i) == (ways >> 1))
                        row_new[i] = tag_reg;
            end
        end
    end

    // sequencer: fill-count sweep after reset, then idle -> read row -> write back
    always_comb
    begin
        state_next = state_reg;
        q_take     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SW'(MAX_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid && (!ovalid_reg || pop))
                begin
                    q_take     = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            rt_reg     <= '0;
            rm_reg     <= '0;
            wt_reg     <= '0;
            wm_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + SW'(1);
            if (state_reg == ST_WRITE)
            begin
                ovalid_reg <= 1'b1;
                if (wr_reg)
                begin
                    wt_reg <= wt_reg + 32'd1;
                    if (!hit) wm_reg <= wm_reg + 32'd1;
                end
                else
                begin
                    rt_reg <= rt_reg + 32'd1;
                    if (!hit) rm_reg <= rm_reg + 32'd1;
                end
            end
            else if (pop)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath and memories
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
            wr_reg  <= q_write;
        end
        if (state_reg == ST_CLEAR)
            fill_mem[clr_reg] <= '0;
        if (state_reg == ST_IDLE)
        begin
            row_rd  <= tag_mem[q_set];
            fill_rd <= fill_mem[q_set];
        end
        if (state_reg == ST_WRITE)
        begin
            tag_mem[set_reg]  <= row_new;
            fill_mem[set_reg] <= fill_new;
            hit_reg           <= hit;
        end
    end

    assign empty                   = !ovalid_reg;
    assign out_word.hit            = hit_reg;
    assign out_word.read_accesses  = rt_reg;
    assign out_word.read_misses    = rm_reg;
    assign out_word.write_accesses = wt_reg;
    assign out_word.write_misses   = wm_reg;
endmodule

[design/set_assoc_cache_tag_model_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model_top
// Cache tag model: front splits addresses, back runs the set update.
//
//   channel   handshake         payload
//   input     push / full       in_word  (sact_in_t)
//   result    pop / empty       out_word (sact_out_t)
//   config    cfg_we            cfg_index, cfg_data
//
// Each word passes through the back end in order: set row read, compare and
// row/fill write-back, then return to idle; the single-ported set row
// memory sets this. The front queue holds two words so push continues
// while the back end works. A finished result held on a stalled pop
// holds the back end. After reset the back end sweeps the fill counts
// to zero over all MAX_SETS sets (1024 by default) before taking a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module set_assoc_cache_tag_model_top import sact_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  sact_in_t   in_word,
    output logic       empty,
    input  logic       pop,
    output sact_out_t  out_word,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);
    logic [3:0] offset_reg, index_reg, ways_reg;
    logic       policy_reg;
    logic          q_valid, q_take, q_write;
    logic [SW-1:0] q_set;
    logic [31:0]   q_tag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 4'd6;
            index_reg  <= 4'd6;
            ways_reg   <= 4'd4;
            policy_reg <= POL_LRU;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET: offset_reg <= cfg_data;
                REG_INDEX:  index_reg  <= cfg_data;
                REG_WAYS:   ways_reg   <= cfg_data;
                REG_POLICY: policy_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    sact_front #(.MAX_SETS(MAX_SETS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .offset_bits(offset_reg), .index_bits(index_reg),
        .q_valid(q_valid), .q_take(q_take), .q_write(q_write),
        .q_set(q_set), .q_tag(q_tag)
    );

    sact_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_write(q_write), .q_set(q_set), .q_tag(q_tag),
        .ways_in_use(ways_reg), .policy_mode(policy_reg),
        .empty(empty), .pop(pop), .out_word(out_word)
    );
endmodule

[design/sact_checker.sv]
// ----------------------------------------------------------------------------
// sact_checker
// Port-level checks on the cache tag model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_model_top_macros.svh"
module sact_checker import sact_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input sact_out_t out_word
);
    `SACT_ASSERT_NEXT(a_hold, clk, rst_n, empty == 1'b0 && pop == 1'b0, empty == 1'b0 && $stable(out_word), "result changed while stalled")
    `SACT_ASSERT_NEXT(a_rd_step, clk, rst_n, empty == 1'b0 && pop == 1'b1, $stable(out_word.read_accesses) || out_word.read_accesses == $past(out_word.read_accesses) + 32'd1, "read count skipped")
    `SACT_ASSERT_IMP(a_miss_le, clk, rst_n, empty == 1'b0 && out_word.hit == 1'b0 && $rose(empty == 1'b0), out_word.read_misses != $past(out_word.read_misses) || out_word.write_misses != $past(out_word.write_misses), "miss not counted")
    `SACT_ASSERT_NEXT(a_full_rst, clk, rst_n, !$past(rst_n), full == 1'b0 || $past(push), "queue full out of reset")
endmodule

bind set_assoc_cache_tag_model_top sact_checker u_chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .out_word(out_word)
);

[tb/tb_set_assoc_cache_tag_model_top.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_model_top
// Self-checking bench for the cache tag model: a local set model (LRU and fixed) predicts
// hit and the four running counters for every word, checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_set_assoc_cache_tag_model_top;
    import sact_pkg::*;

    localparam int NSETS = DEF_MAX_SETS;
    localparam int NWAYS = DEF_MAX_WAYS;
    localparam int LIMIT_CYCLES = 400000;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    sact_in_t   in_word;
    logic       empty;
    logic       pop;
    sact_out_t  out_word;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    set_assoc_cache_tag_model_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .empty(empty), .pop(pop), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic [31:0] tags [NSETS*NWAYS];
    logic [3:0]  fill_cnt [NSETS];
    logic [31:0] rd_total, rd_miss, wr_total, wr_miss;
    logic [3:0]  m_offset, m_index, m_ways;
    logic        m_policy;

    sact_out_t   expected_q [$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          hits_seen;
    int          cycle_count;
    bit          send_gaps;
    bit          pop_gaps;
    int          hold_off;
    logic [31:0] recent_addr [$];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // apply one access to the model and queue its result
    task automatic predict_access(input sact_in_t w);
        logic [31:0] above, tag, mask;
        int set, fill, ways, pos, i;
        bit hit;
        sact_out_t r;
        begin
            above = (m_offset >= 32) ? 32'd0 : (w.address >> m_offset);
            mask  = (m_index >= 32) ? 32'hFFFF_FFFF : ((32'd1 << m_index) - 32'd1);
            set   = int'((above & mask) % NSETS);
            tag   = (m_index >= 32) ? 32'd0 : (above >> m_index);
            ways  = (m_ways < 1) ? 1 : ((m_ways > NWAYS) ? NWAYS : int'(m_ways));
            fill  = (fill_cnt[set] > NWAYS) ? NWAYS : int'(fill_cnt[set]);
            hit   = 1'b0;
            pos   = 0;
            for (i = 0; i < fill; i++)
            begin
                if (!hit && tags[set*NWAYS+i] == tag)
                begin
                    hit = 1'b1;
                    pos = i;
                end
            end
            if (m_policy == POL_LRU)
            begin
                if (hit || fill >= ways)
                begin
                    for (i = (hit ? pos : 0); i + 1 < fill; i++)
                        tags[set*NWAYS+i] = tags[set*NWAYS+i+1];
                    tags[set*NWAYS+fill-1] = tag;
                end
                else
                begin
                    tags[set*NWAYS+fill] = tag;
                    fill++;
                end
            end
            else if (!hit)
            begin
                if (fill < ways)
                begin
                    tags[set*NWAYS+fill] = tag;
                    fill++;
                end
                else
                    tags[set*NWAYS+ways/2] = tag;
            end
            fill_cnt[set] = fill[3:0];
            if (w.is_write)
            begin
                wr_total++;
                if (!hit) wr_miss++;
            end
            else
            begin
                rd_total++;
                if (!hit) rd_miss++;
            end
            r.hit = hit;
            r.read_accesses = rd_total;
            r.read_misses = rd_miss;
            r.write_accesses = wr_total;
            r.write_misses = wr_miss;
            expected_q = {expected_q, r};
        end
    endtask

    // send one word, with optional random gap before it; push stays high after
    task automatic send_word(input logic wr, input logic [31:0] addr);
        sact_in_t w;
        int gap;
        begin
            if (send_gaps && $urandom_range(0, 3) == 0)
            begin
                push <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(negedge clk);
            end
            w.is_write = wr;
            w.address = addr;
            in_word <= w;
            push <= 1'b1;
            @(posedge clk);
            while (full) @(posedge clk);
            predict_access(w);
            words_sent++;
            recent_addr = {recent_addr, addr};
            if (recent_addr.size() > 24) void'(recent_addr.pop_front());
            @(negedge clk);
        end
    endtask

    // stop sending, wait for all results, then a settle pause
    task automatic drain;
        begin
            push <= 1'b0;
            while (expected_q.size() != 0) @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        begin
            cfg_index <= idx;
            cfg_data <= val;
            cfg_we <= 1'b1;
            @(negedge clk);
            case (idx)
                REG_OFFSET: m_offset = val;
                REG_INDEX:  m_index = val;
                REG_WAYS:   m_ways = val;
                default:    m_policy = val[0];
            endcase
        end
    endtask

    task automatic set_config(input logic [3:0] off, input logic [3:0] idx,
                              input logic [3:0] ways, input logic pol);
        begin
            drain();
            write_reg(REG_OFFSET, off);
            write_reg(REG_INDEX, idx);
            write_reg(REG_WAYS, ways);
            write_reg(REG_POLICY, pol);
            cfg_we <= 1'b0;
        end
    endtask

    // pick an address that tends to land in few sets and reuse tags
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        int k;
        begin
            k = $urandom_range(0, 9);
            if (k < 4 && recent_addr.size() > 0)
                a = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
            else if (k < 8)
            begin
                a = {8'($urandom_range(0, 15)), 24'd0} | ($urandom_range(0, 3) << m_offset)
                    | ($urandom & ((32'd1 << m_offset) - 1));
                a = a | (32'($urandom_range(0, 7)) << (5'(m_offset) + 5'(m_index)));
            end
            else
                a = $urandom;
            pick_address = a;
        end
    endfunction

    // directed: field extremes and special cases
    task automatic test_directed;
        int i;
        begin
            send_word(1'b0, 32'h0000_0000);
            send_word(1'b0, 32'h0000_0000);
            send_word(1'b1, 32'hFFFF_FFFF);
            send_word(1'b1, 32'hFFFF_FFFF);
            // five tags into one set with four ways: LRU eviction
            for (i = 0; i < 5; i++) send_word(i[0], 32'(i) << 12);
            send_word(1'b0, 32'h0000_0000);
            send_word(1'b0, 32'h0000_4000);
            // wide split: offset+index reach past 32 is not possible at 4 bits,
            // so use maximum widths with index beyond the set range
            set_config(4'd15, 4'd15, 4'd8, POL_LRU);
            send_word(1'b0, 32'hFFFF_FFFF);
            send_word(1'b1, 32'h8000_0000);
            send_word(1'b0, 32'hFFFF_FFFF);
            // ways 0 acts as 1; saturating ways above range
            set_config(4'd0, 4'd0, 4'd0, POL_FIXED);
            for (i = 0; i < 3; i++) send_word(1'b1, 32'(i + 1));
            set_config(4'd0, 4'd0, 4'd15, POL_FIXED);
            for (i = 0; i < 11; i++) send_word(i[1], 32'(i * 3));
            // ways reduced with a full set
            set_config(4'd0, 4'd0, 4'd2, POL_LRU);
            send_word(1'b0, 32'd100);
            send_word(1'b0, 32'd0);
        end
    endtask

    // random phases over several configurations
    task automatic test_random_phase(input int count);
        int i;
        begin
            for (i = 0; i < count; i++)
                send_word(logic'($urandom_range(0, 1)), pick_address());
        end
    endtask

    task automatic test_random;
        begin
            set_config(4'd6, 4'd6, 4'd4, POL_LRU);
            test_random_phase(90);
            set_config(4'd12, 4'd10, 4'd8, POL_FIXED);
            test_random_phase(90);
            set_config(4'd0, 4'd1, 4'd1, POL_LRU);
            test_random_phase(80);
            set_config(4'd3, 4'd2, 4'd3, POL_FIXED);
            test_random_phase(80);
            set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), logic'($urandom_range(0, 1)));
            test_random_phase(80);
        end
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure;
        begin
            set_config(4'd4, 4'd3, 4'd5, POL_LRU);
            hold_off = 300;
            test_random_phase(40);
        end
    endtask

    task automatic test_no_gaps;
        begin
            send_gaps = 1'b0;
            pop_gaps = 1'b0;
            set_config(4'd2, 4'd4, 4'd6, POL_LRU);
            test_random_phase(60);
        end
    endtask

    // pop driver
    initial
    begin
        int n;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                pop <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            else if (pop_gaps && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sact_out_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", out_word);
            end
            else
            begin
                e = expected_q.pop_front();
                words_checked++;
                if (out_word.hit) hits_seen++;
                if (out_word !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: expected %p got %p",
                                 words_checked, e, out_word);
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int k;
        rst_n = 1'b0;
        push = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = REG_OFFSET;
        cfg_data = 4'd0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        hits_seen = 0;
        cycle_count = 0;
        hold_off = 0;
        send_gaps = 1'b1;
        pop_gaps = 1'b1;
        rd_total = 0;
        rd_miss = 0;
        wr_total = 0;
        wr_miss = 0;
        m_offset = 4'd6;
        m_index = 4'd6;
        m_ways = 4'd4;
        m_policy = POL_LRU;
        for (k = 0; k < NSETS; k++) fill_cnt[k] = 4'd0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random();
        test_backpressure();
        test_no_gaps();
        drain();

        $display("covered %0d accesses (%0d hits) over LRU and fixed policies,",
                 words_sent, hits_seen);
        $display("register extremes, reduced ways and a long result stall");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
